FILE: design/isodr_pkg.sv
// ----------------------------------------------------------------------------
// isodr_pkg
// Shared types and constants of the directory record parser: controller
// states, result kinds, record field offsets, special characters and register indexes.
// ----------------------------------------------------------------------------
package isodr_pkg;

    // controller states
    typedef enum logic [1:0] {
        ST_BYTE,
        ST_READ,
        ST_CHAR,
        ST_END
    } t_state;

    // configuration register indexes
    localparam logic CFG_DIR_BYTES   = 1'b0;
    localparam logic CFG_ENTRY_LIMIT = 1'b1;

    // result kinds
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // record layout
    localparam logic [7:0] OFF_EXTENT   = 8'd2;
    localparam logic [7:0] OFF_SIZE     = 8'd10;
    localparam logic [7:0] OFF_FLAGS    = 8'd25;
    localparam logic [7:0] OFF_NAME_LEN = 8'd32;
    localparam logic [7:0] OFF_NAME     = 8'd33;
    localparam logic [7:0] REC_MIN_LEN  = 8'd34;
    localparam logic [7:0] FLAG_DIR     = 8'h02;

    // special name characters
    localparam logic [7:0] CHAR_SEMI = 8'h3B;
    localparam logic [7:0] CHAR_DOT  = 8'h2E;

endpackage

FILE: design/iso9660_directory_record_parser.sv
// Sequencing: a kept record's name run starts once its last byte is taken; each
//   character passes through ST_READ (name store read), then ST_CHAR (output load).
// Throughput: one directory byte per cycle while no name run is in flight and
//   the output register can take a result.
// Reset (i_rst_n low, synchronous): all parse state cleared, directory size
//   set to zero and entry limit to 64; the name store holds no defined data.
// ----------------------------------------------------------------------------
// iso9660_directory_record_parser
// Splits a stream of directory bytes into records, gathers extent, size,
// directory flag and name of each record, and emits every kept name as a
// run of character transactions, followed by one end-of-listing result.
// ----------------------------------------------------------------------------
module iso9660_directory_record_parser #(
    parameter int NAME_MAX     = 32,
    parameter int SECTOR_BYTES = 2048,
    parameter int MAX_ENTRIES  = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    // byte input
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // dir_byte[7:0]
    input  logic        i_s_tuser,   // first_byte
    // result output
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // name_char[7:0], char_index[12:8], name_length[17:13], extent_lba[49:18],
    // file_bytes[81:50], is_dir[82], entry_index[88:83], entry_count[95:89]
    output logic [95:0] o_m_tdata,
    output logic        o_m_tuser,   // kind
    output logic        o_m_tlast    // last
);

    import isodr_pkg::*;

    localparam int NAME_CAP = NAME_MAX - 1;
    localparam int NW       = $clog2(NAME_MAX);
    localparam int AW       = (NAME_CAP > 1) ? $clog2(NAME_CAP) : 1;
    localparam int SW       = $clog2(SECTOR_BYTES);
    localparam int CW       = $clog2(MAX_ENTRIES + 1);
    localparam int LW       = (CW > 7) ? CW : 7;

    localparam logic [NW-1:0] NAME_CAP_V   = NW'(NAME_CAP);
    localparam logic [SW-1:0] SEC_LAST     = SW'(SECTOR_BYTES - 1);
    localparam logic [32:0]   SECTOR_V     = 33'(SECTOR_BYTES);
    localparam logic [LW-1:0] MAX_ENT_V    = LW'(MAX_ENTRIES);

    // configuration registers
    logic [31:0]   r_dir_bytes;
    logic [6:0]    r_entry_limit;

    // parse state
    t_state        r_state, n_state;
    logic [31:0]   r_pos, n_pos;
    logic [SW-1:0] r_sec_off, n_sec_off;
    logic [7:0]    r_rec_off, n_rec_off;
    logic [7:0]    r_rec_len, n_rec_len;
    logic          r_pad, n_pad;
    logic [31:0]   r_ext, n_ext;
    logic [31:0]   r_size, n_size;
    logic          r_dir, n_dir;
    logic [7:0]    r_decl, n_decl;
    logic [NW-1:0] r_fill, n_fill;
    logic [NW-1:0] r_keep, n_keep;
    logic          r_ended, n_ended;
    logic          r_rej, n_rej;
    logic [CW-1:0] r_found, n_found;
    logic          r_done, n_done;

    // name run control
    logic [NW-1:0] r_emit_len, n_emit_len;
    logic [NW-1:0] r_emit_idx, n_emit_idx;
    logic [CW-1:0] r_emit_entry, n_emit_entry;
    logic          r_end_pend, n_end_pend;

    // output register
    logic          r_out_valid;
    logic          r_o_kind;
    logic          r_o_last;
    logic [7:0]    r_o_char;
    logic [4:0]    r_o_cidx;
    logic [4:0]    r_o_nlen;
    logic [31:0]   r_o_ext;
    logic [31:0]   r_o_size;
    logic          r_o_dir;
    logic [5:0]    r_o_eidx;
    logic [6:0]    r_o_cnt;

    // combinational helpers
    logic          slot_free;
    logic          s_fire;
    logic          ld_end;
    logic          ld_char;
    logic          go;
    logic          end_after;
    logic [LW-1:0] lim_now;
    logic [32:0]   boundary;
    logic [7:0]    name_pos;
    logic [1:0]    lane;
    logic [7:0]    rd_data;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;

    // ------------------------------------------------------------------------
    // name store
    // ------------------------------------------------------------------------
    isodr_name_ram #(
        .DEPTH (NAME_CAP),
        .AW    (AW)
    ) u_name_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_s_tdata),
        .i_raddr (r_emit_idx[AW-1:0]),
        .o_rdata (rd_data)
    );

    // ------------------------------------------------------------------------
    // handshake and limit
    // ------------------------------------------------------------------------
    assign slot_free  = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == ST_BYTE) && slot_free;
    assign s_fire     = i_s_tvalid && o_s_tready;
    assign lim_now    = (LW'(r_entry_limit) > MAX_ENT_V) ? MAX_ENT_V : LW'(r_entry_limit);

    // ------------------------------------------------------------------------
    // byte parsing and name run sequencing
    // ------------------------------------------------------------------------
    always_comb begin
        n_state      = r_state;
        n_pos        = r_pos;
        n_sec_off    = r_sec_off;
        n_rec_off    = r_rec_off;
        n_rec_len    = r_rec_len;
        n_pad        = r_pad;
        n_ext        = r_ext;
        n_size       = r_size;
        n_dir        = r_dir;
        n_decl       = r_decl;
        n_fill       = r_fill;
        n_keep       = r_keep;
        n_ended      = r_ended;
        n_rej        = r_rej;
        n_found      = r_found;
        n_done       = r_done;
        n_emit_len   = r_emit_len;
        n_emit_idx   = r_emit_idx;
        n_emit_entry = r_emit_entry;
        n_end_pend   = r_end_pend;
        ld_end       = 1'b0;
        ld_char      = 1'b0;
        go           = 1'b0;
        end_after    = 1'b0;
        boundary     = 33'({1'b0, r_pos} - 33'(r_sec_off)) + SECTOR_V;
        name_pos     = 8'd0;
        lane         = 2'd0;
        ram_we       = 1'b0;
        ram_waddr    = r_fill[AW-1:0];

        case (r_state)
            ST_BYTE: begin
                if (s_fire) begin
                    // first byte of a directory clears the running state
                    if (i_s_tuser) begin
                        n_pos     = '0;
                        n_sec_off = '0;
                        n_rec_off = '0;
                        n_rec_len = '0;
                        n_pad     = 1'b0;
                        n_ext     = '0;
                        n_size    = '0;
                        n_dir     = 1'b0;
                        n_decl    = '0;
                        n_fill    = '0;
                        n_keep    = '0;
                        n_ended   = 1'b0;
                        n_rej     = 1'b0;
                        n_found   = '0;
                        n_done    = 1'b0;
                    end
                    boundary  = 33'({1'b0, n_pos} - 33'(n_sec_off)) + SECTOR_V;
                    ram_waddr = n_fill[AW-1:0];

                    if (!n_done) begin
                        if (n_pos >= r_dir_bytes || LW'(n_found) >= lim_now) begin
                            // directory exhausted or limit already reached
                            ld_end = 1'b1;
                        end else begin
                            go = 1'b1;
                            // skip sector padding up to the next boundary
                            if (n_pad) begin
                                if (n_sec_off != '0) begin
                                    go        = 1'b0;
                                    n_pos     = n_pos + 32'd1;
                                    n_sec_off = (n_sec_off == SEC_LAST) ? '0 : n_sec_off + 1'b1;
                                end else begin
                                    n_pad = 1'b0;
                                end
                            end
                            // length byte of a new record
                            if (go && n_rec_off == 8'd0) begin
                                if (i_s_tdata == 8'd0) begin
                                    go = 1'b0;
                                    if (boundary >= {1'b0, r_dir_bytes}) begin
                                        ld_end = 1'b1;
                                    end else begin
                                        n_pad     = 1'b1;
                                        n_pos     = n_pos + 32'd1;
                                        n_sec_off = (n_sec_off == SEC_LAST) ? '0
                                                                            : n_sec_off + 1'b1;
                                    end
                                end else if ({1'b0, n_pos} + 33'(i_s_tdata)
                                             > {1'b0, r_dir_bytes}) begin
                                    go     = 1'b0;
                                    ld_end = 1'b1;
                                end else begin
                                    n_rec_len = i_s_tdata;
                                    n_ext     = '0;
                                    n_size    = '0;
                                    n_dir     = 1'b0;
                                    n_decl    = '0;
                                    n_fill    = '0;
                                    n_keep    = '0;
                                    n_ended   = 1'b0;
                                    n_rej     = (i_s_tdata < REC_MIN_LEN);
                                    ram_waddr = '0;
                                end
                            end
                            // field capture within the record
                            if (go) begin
                                if (n_rec_off >= OFF_EXTENT && n_rec_off < OFF_EXTENT + 8'd4) begin
                                    lane = 2'(n_rec_off - OFF_EXTENT);
                                    n_ext[{lane, 3'b000} +: 8] = i_s_tdata;
                                end else if (n_rec_off >= OFF_SIZE
                                             && n_rec_off < OFF_SIZE + 8'd4) begin
                                    lane = 2'(n_rec_off - OFF_SIZE);
                                    n_size[{lane, 3'b000} +: 8] = i_s_tdata;
                                end else if (n_rec_off == OFF_FLAGS) begin
                                    n_dir = (i_s_tdata & FLAG_DIR) != 8'd0;
                                end else if (n_rec_off == OFF_NAME_LEN) begin
                                    n_decl = i_s_tdata;
                                end else if (n_rec_off >= OFF_NAME) begin
                                    name_pos = n_rec_off - OFF_NAME;
                                    // dot entries carry a single 0x00 or 0x01 name byte
                                    if (n_rec_off == OFF_NAME && n_decl == 8'd1
                                        && i_s_tdata <= 8'd1) begin
                                        n_rej = 1'b1;
                                    end
                                    if (name_pos < n_decl && !n_ended && n_fill < NAME_CAP_V) begin
                                        if (i_s_tdata == CHAR_SEMI) begin
                                            n_ended = 1'b1;
                                        end else begin
                                            ram_we = 1'b1;
                                            // track length without trailing dots
                                            if (i_s_tdata != CHAR_DOT) begin
                                                n_keep = n_fill + 1'b1;
                                            end
                                            n_fill = n_fill + 1'b1;
                                        end
                                    end
                                end

                                n_pos     = n_pos + 32'd1;
                                n_sec_off = (n_sec_off == SEC_LAST) ? '0 : n_sec_off + 1'b1;

                                if ({1'b0, n_rec_off} + 9'd1 < {1'b0, n_rec_len}) begin
                                    n_rec_off = n_rec_off + 8'd1;
                                end else begin
                                    // last byte of the record
                                    n_rec_off = 8'd0;
                                    if (!n_rej && n_keep != '0) begin
                                        end_after = (n_pos >= r_dir_bytes)
                                                    || (LW'(n_found) + LW'(1) >= lim_now);
                                        n_emit_len   = n_keep;
                                        n_emit_idx   = '0;
                                        n_emit_entry = n_found;
                                        n_found      = n_found + 1'b1;
                                        n_end_pend   = end_after;
                                        n_done       = end_after;
                                        n_state      = ST_READ;
                                    end else if (n_pos >= r_dir_bytes
                                                 || LW'(n_found) >= lim_now) begin
                                        ld_end = 1'b1;
                                    end
                                end
                            end
                        end
                    end
                    if (ld_end) begin
                        n_done = 1'b1;
                    end
                end
            end

            ST_READ: begin
                // name store read in flight
                n_state = ST_CHAR;
            end

            ST_CHAR: begin
                if (slot_free) begin
                    ld_char = 1'b1;
                    if (r_emit_idx + 1'b1 == r_emit_len) begin
                        n_state = r_end_pend ? ST_END : ST_BYTE;
                    end else begin
                        n_emit_idx = r_emit_idx + 1'b1;
                        n_state    = ST_READ;
                    end
                end
            end

            ST_END: begin
                if (slot_free) begin
                    ld_end     = 1'b1;
                    n_end_pend = 1'b0;
                    n_state    = ST_BYTE;
                end
            end

            default: begin
                n_state = ST_BYTE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir_bytes   <= '0;
            r_entry_limit <= 7'd64;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DIR_BYTES:   r_dir_bytes   <= i_cfg_data;
                CFG_ENTRY_LIMIT: r_entry_limit <= i_cfg_data[6:0];
                default:         r_dir_bytes   <= r_dir_bytes;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // parse state registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_BYTE;
            r_pos        <= '0;
            r_sec_off    <= '0;
            r_rec_off    <= '0;
            r_rec_len    <= '0;
            r_pad        <= 1'b0;
            r_ext        <= '0;
            r_size       <= '0;
            r_dir        <= 1'b0;
            r_decl       <= '0;
            r_fill       <= '0;
            r_keep       <= '0;
            r_ended      <= 1'b0;
            r_rej        <= 1'b0;
            r_found      <= '0;
            r_done       <= 1'b0;
            r_emit_len   <= '0;
            r_emit_idx   <= '0;
            r_emit_entry <= '0;
            r_end_pend   <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pos        <= n_pos;
            r_sec_off    <= n_sec_off;
            r_rec_off    <= n_rec_off;
            r_rec_len    <= n_rec_len;
            r_pad        <= n_pad;
            r_ext        <= n_ext;
            r_size       <= n_size;
            r_dir        <= n_dir;
            r_decl       <= n_decl;
            r_fill       <= n_fill;
            r_keep       <= n_keep;
            r_ended      <= n_ended;
            r_rej        <= n_rej;
            r_found      <= n_found;
            r_done       <= n_done;
            r_emit_len   <= n_emit_len;
            r_emit_idx   <= n_emit_idx;
            r_emit_entry <= n_emit_entry;
            r_end_pend   <= n_end_pend;
        end
    end

    // ------------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= (r_out_valid && !i_m_tready) || ld_end || ld_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_char) begin
            r_o_kind <= KIND_CHAR;
            r_o_last <= (r_emit_idx + 1'b1 == r_emit_len);
            r_o_char <= rd_data;
            r_o_cidx <= 5'(r_emit_idx);
            r_o_nlen <= 5'(r_emit_len);
            r_o_ext  <= r_ext;
            r_o_size <= r_size;
            r_o_dir  <= r_dir;
            r_o_eidx <= 6'(r_emit_entry);
            r_o_cnt  <= '0;
        end else if (ld_end) begin
            r_o_kind <= KIND_END;
            r_o_last <= 1'b1;
            r_o_char <= '0;
            r_o_cidx <= '0;
            r_o_nlen <= '0;
            r_o_ext  <= '0;
            r_o_size <= '0;
            r_o_dir  <= 1'b0;
            r_o_eidx <= '0;
            r_o_cnt  <= 7'(n_found);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_o_kind;
    assign o_m_tlast  = r_o_last;
    assign o_m_tdata  = {r_o_cnt, r_o_eidx, r_o_dir, r_o_size, r_o_ext,
                         r_o_nlen, r_o_cidx, r_o_char};

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    // bytes are taken only while no name run is in flight
    a_ready_only_in_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> (r_state == ST_BYTE))
        else $error("input ready outside byte state");

    // a character result always lies inside its name
    a_char_in_name: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_o_kind == KIND_CHAR) |-> (r_o_cidx < r_o_nlen))
        else $error("character index beyond name length");

    // the name store is never filled beyond its depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill <= NAME_CAP_V) && (r_keep <= r_fill))
        else $error("name fill out of range");

    // loading an end result always leaves the listing marked done
    a_end_sets_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ld_end |=> r_done)
        else $error("end result without listing done");

    // the entry count never passes the MAX_ENTRIES parameter
    a_found_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        LW'(r_found) <= MAX_ENT_V)
        else $error("entry count beyond maximum");

endmodule

FILE: design/isodr_name_ram.sv
// ----------------------------------------------------------------------------
// isodr_name_ram
// Name character store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module isodr_name_ram #(
    parameter int DEPTH = 31,
    parameter int AW    = 5
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
